FILE: rtl/core/uts_pkg.sv
// Shared constants and types of the UTF-8 text sanitizer.
package uts_pkg;

  localparam int MAX_CAPACITY = 4096;
  localparam int CAP_W        = 13;
  localparam int POS_W        = 12;
  localparam int CP_W         = 21;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DECODE = 2'd1,
    PH_HOLD   = 2'd2,
    PH_REJECT = 2'd3
  } uts_phase_e;

  // Results caused by one input byte: up to four text bytes, then a verdict.
  typedef struct packed {
    logic [2:0]             n_bytes;
    logic [3:0][7:0]        bytes;
    logic [POS_W-1:0]       base_pos;
    logic                   has_verdict;
    logic                   accepted;
    logic [POS_W-1:0]       length;
  } uts_group_t;

endpackage

FILE: rtl/core/uts_in_if.sv
// Input byte channel.
interface uts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

FILE: rtl/core/uts_out_if.sv
// Result channel.
interface uts_out_if;
  logic                      valid;
  logic                      ready;
  logic                      item_kind;
  logic [7:0]                text_byte;
  logic [uts_pkg::POS_W-1:0] byte_position;
  logic                      accepted;
  logic [uts_pkg::POS_W-1:0] final_length;
  logic                      run_end;

  modport source (output valid, output item_kind, output text_byte, output byte_position,
                  output accepted, output final_length, output run_end, input ready);
  modport sink   (input valid, input item_kind, input text_byte, input byte_position,
                  input accepted, input final_length, input run_end, output ready);
endinterface

FILE: rtl/core/uts_decoder.sv
// Input register, UTF-8 decode and filter state, result group generation.
module uts_decoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [uts_pkg::CAP_W-1:0] capacity_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [7:0]                byte_i,
  input  logic                      eot_i,
  input  logic                      can_load_i,
  output logic                      grp_valid_o,
  output uts_pkg::uts_group_t       grp_o
);
  import uts_pkg::*;

  logic             s0_valid_q;
  logic [7:0]       s0_byte_q;
  logic             s0_eot_q;

  uts_phase_e       phase_q, phase_d;
  logic [2:0][7:0]  pend_q, pend_d;
  logic [1:0]       pcount_q, pcount_d;
  logic [2:0]       seqlen_q, seqlen_d;
  logic [POS_W-1:0] wcount_q, wcount_d;
  logic [POS_W-1:0] vend_q, vend_d;

  logic             advance;
  logic [2:0]       len;
  logic [CP_W-1:0]  cp;
  logic             bad;
  logic             fits;
  logic [CAP_W-1:0] cap_eff;
  logic [7:0]       b;

  assign b          = s0_byte_q;
  assign advance    = s0_valid_q && can_load_i;
  assign in_ready_o = !s0_valid_q || can_load_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s0_byte_q <= byte_i;
      s0_eot_q  <= eot_i;
    end
  end

  assign len     = (seqlen_q == 3'd0) ? 3'd1 : seqlen_q;
  assign cap_eff = (capacity_i > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : capacity_i;
  assign fits    = ({2'b00, wcount_q} + 14'(len) + 14'd1) <= {1'b0, cap_eff};

  always_comb begin
    unique case (len)
      3'd2:    cp = {10'd0, pend_q[0][4:0], b[5:0]};
      3'd3:    cp = {5'd0, pend_q[0][3:0], pend_q[1][5:0], b[5:0]};
      3'd4:    cp = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], b[5:0]};
      default: cp = {13'd0, b};
    endcase
  end

  always_comb begin
    bad = 1'b0;
    unique case (len)
      3'd2:    bad = cp < CP_W'('h80);
      3'd3:    bad = (cp < CP_W'('h800)) || ((cp >= CP_W'('hd800)) && (cp <= CP_W'('hdfff)));
      3'd4:    bad = (cp < CP_W'('h10000)) || (cp > CP_W'('h10ffff));
      default: bad = 1'b0;
    endcase
    if ((cp < CP_W'('h20)) && (cp != CP_W'('h09))) bad = 1'b1;
    if ((cp == CP_W'('h7f)) || ((cp >= CP_W'('h80)) && (cp <= CP_W'('h9f)))) bad = 1'b1;
    if ((cp == CP_W'('h2028)) || (cp == CP_W'('h2029)) || (cp == CP_W'('hfeff))) bad = 1'b1;
  end

  always_comb begin
    logic do_dec;
    logic fin;
    logic ok;
    phase_d  = phase_q;
    pend_d   = pend_q;
    pcount_d = pcount_q;
    seqlen_d = seqlen_q;
    wcount_d = wcount_q;
    vend_d   = vend_q;
    grp_o             = '0;
    grp_o.base_pos    = wcount_q;
    grp_o.bytes[0]    = (len == 3'd1) ? b : pend_q[0];
    grp_o.bytes[1]    = (len == 3'd2) ? b : pend_q[1];
    grp_o.bytes[2]    = (len == 3'd3) ? b : pend_q[2];
    grp_o.bytes[3]    = b;
    do_dec = 1'b0;
    fin    = 1'b0;
    ok     = 1'b0;

    unique case (phase_q)
      PH_SKIP: begin
        if (b == 8'h00) begin
          phase_d = PH_HOLD;
        end else if ((b != 8'h20) && (b != 8'h09)) begin
          phase_d = PH_DECODE;
          do_dec  = 1'b1;
        end
      end
      PH_DECODE: do_dec = 1'b1;
      default: ;
    endcase

    if (do_dec) begin
      if (seqlen_q == 3'd0) begin
        priority if (b == 8'h00) begin
          phase_d = PH_HOLD;
        end else if (!b[7]) begin
          fin = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          pend_d[0] = b; pcount_d = 2'd1; seqlen_d = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
          pend_d[0] = b; pcount_d = 2'd1; seqlen_d = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
          pend_d[0] = b; pcount_d = 2'd1; seqlen_d = 3'd4;
        end else begin
          phase_d = PH_REJECT;
        end
      end else if (b[7:6] != 2'b10) begin
        phase_d = PH_REJECT;
      end else if (({1'b0, pcount_q} + 3'd1) >= seqlen_q) begin
        fin = 1'b1;
      end else begin
        pend_d[pcount_q] = b;
        pcount_d         = pcount_q + 2'd1;
      end
    end

    if (fin) begin
      if (bad) begin
        phase_d = PH_REJECT;
      end else begin
        pcount_d = 2'd0;
        seqlen_d = 3'd0;
        if (!fits) begin
          phase_d = PH_HOLD;
        end else begin
          grp_o.n_bytes = len;
          wcount_d      = wcount_q + POS_W'(len);
          if ((cp != CP_W'('h20)) && (cp != CP_W'('h09))) vend_d = wcount_d;
        end
      end
    end

    if (s0_eot_q) begin
      if ((phase_d == PH_DECODE) && (seqlen_d != 3'd0)) phase_d = PH_REJECT;
      ok                = (phase_d != PH_REJECT) && (vend_d != '0);
      grp_o.has_verdict = 1'b1;
      grp_o.accepted    = ok;
      grp_o.length      = ok ? vend_d : '0;
      phase_d  = PH_SKIP;
      pcount_d = 2'd0;
      seqlen_d = 3'd0;
      wcount_d = '0;
      vend_d   = '0;
    end
  end

  assign grp_valid_o = advance && ((grp_o.n_bytes != 3'd0) || grp_o.has_verdict);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SKIP;
      pcount_q <= 2'd0;
      seqlen_q <= 3'd0;
      wcount_q <= '0;
      vend_q   <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      pcount_q <= pcount_d;
      seqlen_q <= seqlen_d;
      wcount_q <= wcount_d;
      vend_q   <= vend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) pend_q <= pend_d;
  end

  a_seq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seqlen_q == 3'd0) == (pcount_q == 2'd0))
    else $error("pending count out of step with sequence length");
  a_count_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seqlen_q != 3'd0) |-> ({1'b0, pcount_q} < seqlen_q))
    else $error("pending count reached sequence length");
  a_skip_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_SKIP) |-> ((wcount_q == '0) && (vend_q == '0)))
    else $error("bytes written while skipping leading blanks");
  a_vend_le_wcount: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vend_q <= wcount_q)
    else $error("visible end beyond written count");

endmodule

FILE: rtl/core/uts_serializer.sv
// Result group register; emits one result beat per cycle while the output is ready.
module uts_serializer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                grp_valid_i,
  input  uts_pkg::uts_group_t grp_i,
  output logic                can_load_o,
  uts_out_if.source           out_o
);
  import uts_pkg::*;

  logic       busy_q;
  logic [2:0] idx_q;
  uts_group_t grp_q;
  logic [2:0] total;
  logic       last;
  logic       take;
  logic       kind;

  assign total      = grp_q.n_bytes + {2'b00, grp_q.has_verdict};
  assign last       = idx_q == (total - 3'd1);
  assign take       = out_o.valid && out_o.ready;
  assign can_load_o = !busy_q || (take && last);
  assign kind       = idx_q >= grp_q.n_bytes;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else if (grp_valid_i) begin
      busy_q <= 1'b1;
      idx_q  <= 3'd0;
    end else if (take) begin
      if (last) begin
        busy_q <= 1'b0;
        idx_q  <= 3'd0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_valid_i) grp_q <= grp_i;
  end

  assign out_o.valid         = busy_q;
  assign out_o.item_kind     = kind;
  assign out_o.text_byte     = kind ? 8'h00 : grp_q.bytes[idx_q[1:0]];
  assign out_o.byte_position = kind ? '0 : grp_q.base_pos + POS_W'(idx_q);
  assign out_o.accepted      = kind ? grp_q.accepted : 1'b0;
  assign out_o.final_length  = kind ? grp_q.length : '0;
  assign out_o.run_end       = last;

  a_idx_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < total))
    else $error("result index beyond group");
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_valid_i |-> can_load_o)
    else $error("group loaded over pending results");

endmodule

FILE: rtl/core/utf8_text_sanitizer.sv
// Top level of the UTF-8 text sanitizer: capacity register, decoder, result serializer.
// Path: input register, decoder, serializer group register, then the result beats.
// Throughput: one input byte per cycle while the output is ready and each byte
// gives at most one result; more results (up to five) hold the input until all are out.
// Reset: asynchronous active low; clears per-text state, sets capacity to 256.
module utf8_text_sanitizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [uts_pkg::CAP_W-1:0] cfg_wdata_i,
  uts_in_if.sink                    in_i,
  uts_out_if.source                 out_o
);
  import uts_pkg::*;

  logic [CAP_W-1:0] capacity_q;
  logic             can_load;
  logic             grp_valid;
  uts_group_t       grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  uts_decoder u_decoder (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .capacity_i  (capacity_q),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .byte_i      (in_i.byte_in),
    .eot_i       (in_i.end_of_text),
    .can_load_i  (can_load),
    .grp_valid_o (grp_valid),
    .grp_o       (grp)
  );

  uts_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_i       (grp),
    .can_load_o  (can_load),
    .out_o       (out_o)
  );

endmodule
